/* sv/olir_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olir_pkg: shared types for the ordered list core
// Action and status codes, the per-cell shift command and its encoding.
// ----------------------------------------------------------------------------
package olir_pkg;

  // Index fields are wide enough for any supported list depth (up to 256).
  localparam int unsigned IDX_BITS = 9;

  typedef enum logic [2:0] {
    ACT_GET    = 3'd0,
    ACT_SET    = 3'd1,
    ACT_INSERT = 3'd2,
    ACT_APPEND = 3'd3,
    ACT_POP    = 3'd4
  } act_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_WRITE  = 2'd1,
    CELL_INSERT = 2'd2,
    CELL_REMOVE = 2'd3
  } cell_op_e;

  // Broadcast to every cell in the chain each cycle.
  typedef struct packed {
    cell_op_e            op;
    logic [IDX_BITS-1:0] sel;     // target index of the write or shift
    logic [IDX_BITS-1:0] lim;     // entry count before the operation
    logic [IDX_BITS-1:0] rd_pos;  // index whose word is read out
  } cell_cmd_t;

endpackage

/* sv/ordered_list_insert_remove_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_insert_remove_core: fixed-capacity ordered list of words
// A chain of cells that performs get, set, insert, append and pop.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid_i / in_ready_o) carries one transaction per
// operation: an action code, a position and a data word. The output channel
// (out_valid_o / out_ready_i) returns exactly one transaction per input: the
// word read by get or removed by pop (zero otherwise), a status code and the
// entry count after the operation.
// The result is registered at the edge that accepts the input. Throughput
// is one operation per cycle while the receiver takes results, because every
// cell of the chain loads its neighbor's word in the same cycle, so an insert
// or pop moves all entries at once. Reading an entry is an AND-OR combine over
// the cells, which sets the critical path together with the index compares.
// A new input is accepted whenever the output register is empty or being
// emptied in the same cycle; a stalled receiver therefore stalls the input
// after one held result.
// Reset empties the list (count zero) and drops any pending result. The cell
// contents are not cleared: entries at or above the count are never read.
// ----------------------------------------------------------------------------
module ordered_list_insert_remove_core import olir_pkg::*; #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [2:0]                     action_i,
  input  logic [7:0]                     position_i,
  input  logic [31:0]                    item_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [31:0]                    read_value_o,
  output logic [1:0]                     status_o,
  output logic [$clog2(DEPTH+1)-1:0]     count_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  // Stored width: input words are 32 bits, masked to WORD_BITS.
  localparam int unsigned SW = (WORD_BITS < 32) ? WORD_BITS : 32;

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  logic [31:0]      read_value_q, read_value_d;
  status_e          status_q, status_d;
  logic [CNT_W-1:0] out_count_q;

  logic             accept;
  cell_cmd_t        cmd;
  cell_op_e         op_sel;
  logic [IDX_BITS-1:0] sel;
  logic [IDX_BITS-1:0] pos_ext, n_ext;
  logic             in_range, full;
  logic [SW-1:0]    new_word;
  logic [SW-1:0]    words [DEPTH];
  logic [SW-1:0]    rd_parts [DEPTH];
  logic [SW-1:0]    rd_word;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign pos_ext  = IDX_BITS'(position_i);
  assign n_ext    = IDX_BITS'(count_q);
  assign in_range = pos_ext < n_ext;
  assign full     = count_q == CNT_W'(DEPTH);
  assign new_word = item_value_i[SW-1:0];

  // The word at the requested position, gathered from all cells.
  always_comb begin
    rd_word = '0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      rd_word = rd_word | rd_parts[i];
    end
  end

  // Decode the action into a cell command, a result and the next count.
  always_comb begin
    op_sel       = CELL_HOLD;
    sel          = pos_ext;
    count_d      = count_q;
    status_d     = ST_OK;
    read_value_d = '0;
    case (action_i)
      ACT_GET: begin
        if (in_range) read_value_d = 32'(rd_word);
        else          status_d     = ST_RANGE;
      end
      ACT_SET: begin
        if (in_range) op_sel   = CELL_WRITE;
        else          status_d = ST_RANGE;
      end
      ACT_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          // An insert past the end acts as an append.
          op_sel  = CELL_INSERT;
          sel     = (pos_ext > n_ext) ? n_ext : pos_ext;
          count_d = count_q + CNT_W'(1);
        end
      end
      ACT_APPEND: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          op_sel  = CELL_WRITE;
          sel     = n_ext;
          count_d = count_q + CNT_W'(1);
        end
      end
      ACT_POP: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else if (!in_range) begin
          status_d = ST_RANGE;
        end else begin
          op_sel       = CELL_REMOVE;
          read_value_d = 32'(rd_word);
          count_d      = count_q - CNT_W'(1);
        end
      end
      default: begin
        // Unused action codes do nothing and report success.
      end
    endcase
  end

  assign cmd.op     = accept ? op_sel : CELL_HOLD;
  assign cmd.sel    = sel;
  assign cmd.lim    = n_ext;
  assign cmd.rd_pos = pos_ext;

  // The chain: each cell sees its lower and upper neighbor.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [SW-1:0] lower, upper;
    if (g == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = words[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = words[g+1];
    end
    olir_cell #(
      .IDX (g),
      .SW  (SW)
    ) u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .new_word_i (new_word),
      .lower_i    (lower),
      .upper_i    (upper),
      .word_o     (words[g]),
      .rd_o       (rd_parts[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: loaded with each accepted transaction.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      read_value_q <= read_value_d;
      status_q     <= status_d;
      out_count_q  <= count_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign status_o     = status_q;
  assign count_o      = out_count_q;

endmodule

/* sv/olir_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olir_cell: one storage cell of the ordered list chain
// Holds one word; loads the new word, its lower neighbor or its upper neighbor.
// ----------------------------------------------------------------------------
module olir_cell import olir_pkg::*; #(
  parameter int unsigned IDX = 0,
  parameter int unsigned SW  = 32
) (
  input  logic          clk_i,
  input  cell_cmd_t     cmd_i,
  input  logic [SW-1:0] new_word_i,
  input  logic [SW-1:0] lower_i,
  input  logic [SW-1:0] upper_i,
  output logic [SW-1:0] word_o,
  output logic [SW-1:0] rd_o
);

  localparam logic [IDX_BITS-1:0] MY_IDX  = IDX_BITS'(IDX);
  localparam logic [IDX_BITS-1:0] NEXT_IX = IDX_BITS'(IDX + 1);

  logic [SW-1:0] word_q, word_d;

  always_comb begin
    word_d = word_q;
    case (cmd_i.op)
      CELL_WRITE: begin
        if (MY_IDX == cmd_i.sel) word_d = new_word_i;
      end
      CELL_INSERT: begin
        // Entries from the insert point up to the old end move up one place.
        if (MY_IDX == cmd_i.sel) begin
          word_d = new_word_i;
        end else if (MY_IDX > cmd_i.sel && MY_IDX <= cmd_i.lim) begin
          word_d = lower_i;
        end
      end
      CELL_REMOVE: begin
        // Entries above the removed one move down to close the gap.
        if (MY_IDX >= cmd_i.sel && NEXT_IX < cmd_i.lim) word_d = upper_i;
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;
  assign rd_o   = (MY_IDX == cmd_i.rd_pos) ? word_q : '0;

endmodule

/* bench/ordered_list_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_checker: result predictor and comparator for the list core
// Watches both channels, keeps its own copy of the list, predicts the result
// of each accepted operation and compares it with the returned transaction.
// ----------------------------------------------------------------------------
module ordered_list_checker import olir_pkg::*; #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned CNT_BITS  = $clog2(DEPTH+1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [2:0]          action_i,
  input  logic [7:0]          position_i,
  input  logic [31:0]         item_value_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [31:0]         read_value_i,
  input  logic [1:0]          status_i,
  input  logic [CNT_BITS-1:0] count_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam logic [31:0] WORD_MASK =
      (WORD_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << WORD_BITS) - 32'd1);

  typedef struct packed {
    logic [31:0]         word;
    status_e             status;
    logic [CNT_BITS-1:0] count;
  } list_result_t;

  logic [31:0]  list_words [DEPTH];
  int unsigned  list_len;
  list_result_t awaited_results [$];
  int           mismatches;

  // Applies one operation to the shadow list and returns what the core owes.
  task automatic apply_list_op(input logic [2:0] act, input logic [7:0] pos_in,
                               input logic [31:0] value, output list_result_t res);
    int unsigned pos;
    int unsigned k;
    pos        = pos_in;
    res.word   = '0;
    res.status = ST_OK;
    case (act_e'(act))
      ACT_GET: begin
        if (pos < list_len) res.word = list_words[pos];
        else res.status = ST_RANGE;
      end
      ACT_SET: begin
        if (pos < list_len) list_words[pos] = value & WORD_MASK;
        else res.status = ST_RANGE;
      end
      ACT_INSERT: begin
        if (list_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (pos > list_len) pos = list_len;
          for (k = list_len; k > pos; k--) list_words[k] = list_words[k-1];
          list_words[pos] = value & WORD_MASK;
          list_len++;
        end
      end
      ACT_APPEND: begin
        if (list_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          list_words[list_len] = value & WORD_MASK;
          list_len++;
        end
      end
      ACT_POP: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else if (pos >= list_len) begin
          res.status = ST_RANGE;
        end else begin
          res.word = list_words[pos];
          for (k = pos; k + 1 < list_len; k++) list_words[k] = list_words[k+1];
          list_len--;
        end
      end
      default: begin
      end
    endcase
    res.count = CNT_BITS'(list_len);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    list_result_t want;
    list_result_t fresh;
    if (!rst_ni) begin
      awaited_results.delete();
      list_len   = 0;
      mismatches = 0;
      foreach (list_words[i]) list_words[i] = '0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // A result leaving now belongs to an earlier operation, so compare first.
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $error("result transaction with nothing expected");
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (read_value_i !== want.word) begin
            $error("read_value: expected %h, got %h", want.word, read_value_i);
            mismatches++;
          end
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            mismatches++;
          end
          if (count_i !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, count_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        apply_list_op(action_i, position_i, item_value_i, fresh);
        awaited_results.push_back(fresh);
      end
      fail_count_o <= mismatches;
      pending_o    <= awaited_results.size();
    end
  end

endmodule

/* bench/ordered_list_insert_remove_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_insert_remove_core_tb: testbench for the ordered list core
// Drives directed corner cases and biased random operation sequences through
// the input channel while the output side stalls at random; a checker module
// predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module ordered_list_insert_remove_core_tb import olir_pkg::*;;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned CNT_BITS   = $clog2(DEPTH+1);
  localparam int          RANDOM_OPS = 650;
  // Window of transactions during which neither side idles.
  localparam int          QUIET_FROM = 120;
  localparam int          QUIET_TO   = 260;
  // The receiver holds off once, long enough to back the core up completely.
  localparam int          HOLDOFF_AT     = 400;
  localparam int          HOLDOFF_CYCLES = 80;
  localparam int          CYCLE_LIMIT    = 200000;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [2:0]          action_i;
  logic [7:0]          position_i;
  logic [31:0]         item_value_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [31:0]         read_value_o;
  logic [1:0]          status_o;
  logic [CNT_BITS-1:0] count_o;

  int fail_count;
  int pending;
  int ops_sent;
  int cycles;

  ordered_list_insert_remove_core #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .position_i   (position_i),
    .item_value_i (item_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .count_o      (count_o)
  );

  ordered_list_checker #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .action_i     (action_i),
    .position_i   (position_i),
    .item_value_i (item_value_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_value_i (read_value_o),
    .status_i     (status_o),
    .count_i      (count_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake must not run forever.
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** ordered_list_insert_remove_core: FAILED **");
      $finish;
    end
  end

  function automatic bit in_quiet_stretch();
    return ops_sent >= QUIET_FROM && ops_sent < QUIET_TO;
  endfunction

  // Offers one operation and returns once the core has taken the transaction.
  // Valid is only lowered when an idle gap is chosen, so it is never dropped
  // and raised again within one time step. Signals read right after the edge
  // still hold their pre-edge values, which is what the handshake saw.
  task automatic offer_op(input logic [2:0] act, input logic [7:0] pos,
                          input logic [31:0] value);
    while (!in_quiet_stretch() && $urandom_range(0, 99) < 25) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    position_i   <= pos;
    item_value_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    ops_sent++;
  endtask

  // Mostly positions around the live range of the list so that in-range and
  // just-out-of-range indexes dominate; the rest spans the whole field.
  function automatic logic [7:0] random_position();
    if ($urandom_range(0, 99) < 75) return 8'($urandom_range(0, DEPTH + 1));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [31:0] random_word();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return 32'h0000_0000;
    if (pick < 16) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  // Phase 0 leans toward growing the list, phase 1 toward draining it and
  // phase 2 is balanced, so the core spends time both full and empty.
  function automatic logic [2:0] random_action(input int phase);
    int unsigned pick;
    int unsigned grow;
    int unsigned shrink;
    pick = $urandom_range(0, 99);
    case (phase)
      0:       begin grow = 55; shrink = 15; end
      1:       begin grow = 15; shrink = 55; end
      default: begin grow = 35; shrink = 35; end
    endcase
    if (pick < grow / 2) return ACT_INSERT;
    if (pick < grow) return ACT_APPEND;
    if (pick < grow + shrink) return ACT_POP;
    if (pick < grow + shrink + 13) return ACT_GET;
    if (pick < grow + shrink + 26) return ACT_SET;
    return 3'($urandom_range(5, 7));
  endfunction

  // Receiver: random stalls, a quiet window, and one long hold-off while the
  // sender keeps offering, so the core fills and pushes back on its input.
  initial begin : receiver
    bit held_off;
    held_off    = 1'b0;
    out_ready_i = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (!held_off && ops_sent >= HOLDOFF_AT) begin
        held_off = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= in_quiet_stretch() || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  // Sender: reset, directed corner cases, random sequences, then the verdict.
  initial begin : sender
    int i;
    in_valid_i   = 1'b0;
    action_i     = ACT_GET;
    position_i   = '0;
    item_value_i = '0;
    rst_ni       = 1'b0;
    ops_sent     = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty list: pop reports empty, get and set report out of range.
    offer_op(ACT_POP, 8'd0, 32'h0);
    offer_op(ACT_GET, 8'd0, 32'h0);
    offer_op(ACT_SET, 8'd255, 32'hFFFF_FFFF);
    // Insert far past the end is clamped and behaves like an append.
    offer_op(ACT_INSERT, 8'd255, 32'hFFFF_FFFF);
    offer_op(ACT_INSERT, 8'd0, 32'h0000_0000);
    offer_op(ACT_APPEND, 8'd0, 32'hA5A5_A5A5);
    offer_op(ACT_GET, 8'd2, 32'h0);
    offer_op(ACT_SET, 8'd1, 32'h5A5A_5A5A);
    offer_op(ACT_GET, 8'd255, 32'h0);
    // Unused action codes leave the list alone.
    offer_op(3'd5, 8'd3, 32'h1234_5678);
    offer_op(3'd7, 8'd0, 32'hFFFF_FFFF);
    // Fill to capacity with a mix of middle inserts and appends.
    for (i = 0; i < DEPTH - 3; i++) begin
      if (i % 2 == 0) offer_op(ACT_INSERT, 8'($urandom_range(0, 3 + i)), $urandom());
      else offer_op(ACT_APPEND, 8'($urandom_range(0, 255)), $urandom());
    end
    // Full list rejects both kinds of growth.
    offer_op(ACT_INSERT, 8'd0, 32'hDEAD_BEEF);
    offer_op(ACT_APPEND, 8'd0, 32'hDEAD_BEEF);
    // Remove the last and the first entry, then a pop out of range.
    offer_op(ACT_POP, 8'(DEPTH - 1), 32'h0);
    offer_op(ACT_POP, 8'd0, 32'h0);
    offer_op(ACT_POP, 8'd200, 32'h0);

    for (i = 0; i < RANDOM_OPS; i++) begin
      offer_op(random_action((i / 80) % 3), random_position(), random_word());
    end
    in_valid_i <= 1'b0;

    // Drain every outstanding result before the verdict.
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("** ordered_list_insert_remove_core: PASSED **");
    end else begin
      $display("** ordered_list_insert_remove_core: FAILED **");
    end
    $finish;
  end

endmodule
